>>> rtl/sprite_animation_sequencer_defines.svh
// Assertion macros shared by the sprite animation sequencer RTL.
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks a property on every clock edge outside reset.
`define SAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that a condition holds in the cycle after a trigger.
`define SAS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SAS_ASSERT(lbl, prop, msg)
`define SAS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/sas_pkg.sv
// Types, constants and codes shared by the sprite animation sequencer.
package sas_pkg;

  // Sequence table geometry.
  localparam int SEQUENCE_DEPTH = 64;
  localparam int FRAME_BITS     = 12;
  localparam int SEQ_IDX_W      = $clog2(SEQUENCE_DEPTH);
  localparam int SEQ_CNT_W      = $clog2(SEQUENCE_DEPTH + 1);

  // Register and arithmetic widths.
  localparam int CFG_W      = 13;
  localparam int Q_W        = 16;
  localparam int COORD_W    = 17;
  localparam int DIV_STEP_W = $clog2(Q_W + 1);
  localparam int PIX_W      = FRAME_BITS + 1 + CFG_W;

  localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(65536);

  // Action codes.
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_START = 3'd2;
  localparam logic [2:0] ACT_STOP  = 3'd3;
  localparam logic [2:0] ACT_SET   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_TEX_W  = 2'd0;
  localparam logic [1:0] REG_TEX_H  = 2'd1;
  localparam logic [1:0] REG_TILE_W = 2'd2;
  localparam logic [1:0] REG_TILE_H = 2'd3;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] TEX_W_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] TEX_H_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] TILE_W_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0] TILE_H_RST = CFG_W'(16);

  // One input beat.
  typedef struct packed {
    logic [2:0]  action;
    logic [19:0] time_delta;
    logic [11:0] frame_number;
    logic [19:0] frame_period;
    logic        loop_enable;
  } sas_in_t;

  // One output beat.
  typedef struct packed {
    logic [16:0] u_left;
    logic [16:0] v_top;
    logic [16:0] u_right;
    logic [16:0] v_bottom;
    logic [11:0] shown_frame_out;
    logic        is_playing;
    logic [6:0]  entries_loaded;
  } sas_out_t;

  // Divider request: remainder seed, left-aligned numerator bits, step count.
  typedef struct packed {
    logic                  start;
    logic [CFG_W-1:0]      den;
    logic [CFG_W-1:0]      rem_init;
    logic [Q_W-1:0]        num;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  // Divider response; quotient and remainder hold after done.
  typedef struct packed {
    logic             done;
    logic [Q_W-1:0]   quo;
    logic [CFG_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/sas_div.sv
// Shared restoring divider, one quotient bit per cycle.
module sas_div import sas_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] cnt;
  logic [CFG_W-1:0]      den;
  logic [CFG_W-1:0]      rem;
  logic [Q_W-1:0]        num;
  logic [Q_W-1:0]        quo;
  logic [CFG_W:0]        trial;
  logic                  ge;

  // Trial subtraction of the shifted partial remainder.
  assign trial = {rem, num[Q_W-1]};
  assign ge    = trial >= {1'b0, den};

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - DIV_STEP_W'(1);
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      num <= req.num;
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? CFG_W'(trial - {1'b0, den}) : trial[CFG_W-1:0];
      num <= {num[Q_W-2:0], 1'b0};
      quo <= {quo[Q_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

>>> rtl/sprite_animation_sequencer.sv
// Sprite-sheet animation player: one result beat for every input beat.
// Each accepted beat runs the divisions giving tiles per row and row and column, then a
// multiply and a division per coordinate through the shared divider, or a saturated value
// (the left edge never saturates), then the output register; a playing tick first checks the
// period and an advancing tick reads the table. No new beat is taken until the last is done.
// Synchronous reset clears playback state and loads the default sheet geometry.
`include "sprite_animation_sequencer_defines.svh"

module sprite_animation_sequencer import sas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sas_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sas_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_RD, S_SHOW, S_COLS, S_COLS_W, S_ROW, S_ROW_W,
    S_MUL, S_FRAC, S_FRAC_W, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CFG_W-1:0] tex_w;
  logic [CFG_W-1:0] tex_h;
  logic [CFG_W-1:0] tile_w;
  logic [CFG_W-1:0] tile_h;

  // Playback state.
  logic                  playing;
  logic                  loop_flag;
  logic [20:0]           elapsed;
  logic [19:0]           period;
  logic [SEQ_IDX_W-1:0]  pos;
  logic [SEQ_CNT_W-1:0]  count;
  logic [FRAME_BITS-1:0] shown;

  // Coordinate datapath.
  logic [CFG_W-1:0]      cols;
  logic [FRAME_BITS-1:0] col;
  logic [FRAME_BITS-1:0] row;
  logic [1:0]            k;
  logic [PIX_W-1:0]      pix;
  logic [COORD_W-1:0]    coord [4];

  // Sequence table memory.
  logic [FRAME_BITS-1:0] seq_mem [SEQUENCE_DEPTH];
  logic [FRAME_BITS-1:0] rd_data;
  logic                  mem_we;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CFG_W-1:0]  sw, sh, tw, th;
  logic [CFG_W-1:0]  size, extent;
  logic [FRAME_BITS:0] base;
  logic [21:0]       tick_sum;
  logic [20:0]       tick_sat;
  logic              tick_go;
  logic              load_ok;
  logic              pos_more;
  logic              frac_sat;
  logic              accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  // Zero-valued registers act as one.
  assign sw = (tex_w  == '0) ? CFG_W'(1) : tex_w;
  assign sh = (tex_h  == '0) ? CFG_W'(1) : tex_h;
  assign tw = (tile_w == '0) ? CFG_W'(1) : tile_w;
  assign th = (tile_h == '0) ? CFG_W'(1) : tile_h;

  // Saturating accumulation of tick time.
  assign tick_go  = playing && (count != '0);
  assign tick_sum = {1'b0, elapsed} + 22'(in_data.time_delta);
  assign tick_sat = tick_sum[21] ? '1 : tick_sum[20:0];
  assign pos_more = (SEQ_CNT_W'(pos) + SEQ_CNT_W'(1)) < count;
  assign load_ok  = !playing && (count < SEQ_CNT_W'(SEQUENCE_DEPTH));
  assign mem_we   = accept && (in_data.action == ACT_LOAD) && load_ok;

  // Operands of the shared multiplier: the k index picks axis and edge.
  assign base     = {1'b0, (k[0] ? row : col)} + (FRAME_BITS + 1)'(k[1]);
  assign size     = k[0] ? th : tw;
  assign extent   = k[0] ? sh : sw;
  assign frac_sat = pix >= PIX_W'(extent);

  // Table write on load and registered read at the current position.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[count[SEQ_IDX_W-1:0]] <= FRAME_BITS'(in_data.frame_number);
    end
    rd_data <= seq_mem[pos];
  end

  // Divider request selection.
  always_comb begin
    div_req          = '0;
    div_req.den      = cols;
    div_req.rem_init = '0;
    div_req.num      = Q_W'(shown) << (Q_W - FRAME_BITS);
    div_req.steps    = DIV_STEP_W'(FRAME_BITS);
    case (state)
      S_COLS: begin
        div_req.start = 1'b1;
        div_req.den   = tw;
        div_req.num   = Q_W'(sw) << (Q_W - CFG_W);
        div_req.steps = DIV_STEP_W'(CFG_W);
      end
      S_ROW: begin
        div_req.start = 1'b1;
      end
      S_FRAC: begin
        div_req.start    = !frac_sat;
        div_req.den      = extent;
        div_req.rem_init = pix[CFG_W-1:0];
        div_req.num      = '0;
        div_req.steps    = DIV_STEP_W'(Q_W);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  sas_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_w  <= TEX_W_RST;
      tex_h  <= TEX_H_RST;
      tile_w <= TILE_W_RST;
      tile_h <= TILE_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEX_W:  tex_w  <= cfg_data;
        REG_TEX_H:  tex_h  <= cfg_data;
        REG_TILE_W: tile_w <= cfg_data;
        REG_TILE_H: tile_h <= cfg_data;
        default:    tex_w  <= tex_w;
      endcase
    end
  end

  // Sequencer: action, tick advance, coordinate divisions and output beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      playing   <= 1'b0;
      loop_flag <= 1'b0;
      elapsed   <= '0;
      period    <= 20'd1;
      pos       <= '0;
      count     <= '0;
      shown     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result clears, unless the output state loads the next one.
      if (out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_data.action == ACT_TICK && tick_go) ? S_TICK : S_COLS;
            case (in_data.action)
              ACT_TICK: begin
                if (tick_go) begin
                  elapsed <= tick_sat;
                end
              end
              ACT_LOAD: begin
                if (load_ok) begin
                  count <= count + SEQ_CNT_W'(1);
                end
              end
              ACT_START: begin
                if (!playing) begin
                  playing   <= 1'b1;
                  elapsed   <= '0;
                  loop_flag <= in_data.loop_enable;
                  period    <= in_data.frame_period;
                  pos       <= '0;
                end
              end
              ACT_STOP: begin
                playing <= 1'b0;
                count   <= '0;
                pos     <= '0;
              end
              ACT_SET: begin
                shown <= FRAME_BITS'(in_data.frame_number);
              end
              default: begin
                shown <= shown;
              end
            endcase
          end
        end
        S_TICK: begin
          if (elapsed > {1'b0, period}) begin
            elapsed <= elapsed - {1'b0, period};
            if (pos_more) begin
              pos   <= pos + SEQ_IDX_W'(1);
              state <= S_RD;
            end else begin
              pos <= '0;
              if (loop_flag) begin
                state <= S_RD;
              end else begin
                playing <= 1'b0;
                count   <= '0;
                state   <= S_COLS;
              end
            end
          end else begin
            state <= S_COLS;
          end
        end
        S_RD: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          shown <= rd_data;
          state <= S_COLS;
        end
        S_COLS: begin
          state <= S_COLS_W;
        end
        S_COLS_W: begin
          if (div_rsp.done) begin
            cols  <= (div_rsp.quo == '0) ? CFG_W'(1) : CFG_W'(div_rsp.quo);
            state <= S_ROW;
          end
        end
        S_ROW: begin
          state <= S_ROW_W;
        end
        S_ROW_W: begin
          if (div_rsp.done) begin
            row   <= FRAME_BITS'(div_rsp.quo);
            col   <= FRAME_BITS'(div_rsp.rem);
            k     <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pix   <= PIX_W'(base) * PIX_W'(size);
          state <= S_FRAC;
        end
        S_FRAC: begin
          if (frac_sat) begin
            coord[k] <= ONE_Q16;
            k        <= k + 2'd1;
            state    <= (k == 2'd3) ? S_OUT : S_MUL;
          end else begin
            state <= S_FRAC_W;
          end
        end
        S_FRAC_W: begin
          if (div_rsp.done) begin
            coord[k] <= COORD_W'(div_rsp.quo);
            k        <= k + 2'd1;
            state    <= (k == 2'd3) ? S_OUT : S_MUL;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.u_left          <= coord[0];
            out_data.v_top           <= coord[1];
            out_data.u_right         <= coord[2];
            out_data.v_bottom        <= coord[3];
            out_data.shown_frame_out <= 12'(shown);
            out_data.is_playing      <= playing;
            out_data.entries_loaded  <= 7'(count);
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the table depth.
  `SAS_ASSERT(a_count_bound, count <= SEQ_CNT_W'(SEQUENCE_DEPTH), "table count overflow")
  // While playing a filled table, the position stays inside the loaded entries.
  `SAS_ASSERT(a_pos_in_table, (playing && count != '0) |-> (SEQ_CNT_W'(pos) < count), "position past loaded entries")
  // A divider result only arrives while the sequencer waits for one.
  `SAS_ASSERT(a_div_done_waited, div_rsp.done |-> (state == S_COLS_W || state == S_ROW_W || state == S_FRAC_W), "unexpected divider result")
  // An accepted beat always leaves the idle state.
  `SAS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state != S_IDLE, "accepted beat not processed")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the sprite animation sequencer with its own playback predictor.
module tb import sas_pkg::*;;

  // Mirrors the playback state and sheet geometry and holds the predicted
  // coordinate beats that are still waiting for the block's output.
  class frame_coord_scoreboard;
    bit [CFG_W-1:0]      sheet_w, sheet_h, tile_w, tile_h;
    bit                  playing, looping;
    bit [20:0]           elapsed;
    bit [19:0]           period;
    bit [SEQ_IDX_W-1:0]  position;
    bit [SEQ_CNT_W-1:0]  count;
    bit [FRAME_BITS-1:0] frames [SEQUENCE_DEPTH];
    bit [FRAME_BITS-1:0] shown;
    sas_out_t            pending_coords[$];
    int unsigned         mismatches;
    int unsigned         effective_items;

    function new();
      sheet_w = TEX_W_RST;
      sheet_h = TEX_H_RST;
      tile_w  = TILE_W_RST;
      tile_h  = TILE_H_RST;
      period  = 20'd1;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_TEX_W:  sheet_w = value;
        REG_TEX_H:  sheet_h = value;
        REG_TILE_W: tile_w  = value;
        REG_TILE_H: tile_h  = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_coords.size();
    endfunction

    function void clear_table();
      playing  = 1'b0;
      count    = '0;
      position = '0;
    endfunction

    // Accumulates time and steps through the table once the period is passed.
    function void advance(bit [19:0] delta);
      bit [21:0] sum;
      if (!playing || count == 0) return;
      sum = elapsed + delta;
      elapsed = (sum > 22'h1FFFFF) ? 21'h1FFFFF : sum[20:0];
      if (elapsed > period) begin
        elapsed = elapsed - period;
        if (position + 1 < count) begin
          position++;
        end else begin
          position = '0;
          if (!looping) begin
            clear_table();
            return;
          end
        end
        shown = frames[position];
      end
    endfunction

    // Pixel offset over sheet extent as UQ1.16, rounded down, saturated at one.
    function bit [COORD_W-1:0] frac_q16(longint unsigned px, longint unsigned span);
      longint unsigned q;
      q = (px << 16) / span;
      return (q > ONE_Q16) ? ONE_Q16 : COORD_W'(q);
    endfunction

    // Tile rectangle of the shown frame plus the status fields.
    function sas_out_t coords();
      longint unsigned sw, sh, tw, th, cols, col, row;
      sas_out_t r;
      sw = (sheet_w == 0) ? 1 : sheet_w;
      sh = (sheet_h == 0) ? 1 : sheet_h;
      tw = (tile_w == 0) ? 1 : tile_w;
      th = (tile_h == 0) ? 1 : tile_h;
      cols = sw / tw;
      if (cols == 0) cols = 1;
      col = shown % cols;
      row = shown / cols;
      r.u_left          = frac_q16(col * tw, sw);
      r.v_top           = frac_q16(row * th, sh);
      r.u_right         = frac_q16((col + 1) * tw, sw);
      r.v_bottom        = frac_q16((row + 1) * th, sh);
      r.shown_frame_out = shown;
      r.is_playing      = playing;
      r.entries_loaded  = count;
      return r;
    endfunction

    // Applies one accepted input beat and queues the coordinates it yields.
    function void note_item(sas_in_t beat);
      bit [67:0] prior;
      prior = {playing, looping, elapsed, period, position, count, shown};
      case (beat.action)
        ACT_TICK: advance(beat.time_delta);
        ACT_LOAD: begin
          if (!playing && count < SEQUENCE_DEPTH) begin
            frames[count] = beat.frame_number;
            count++;
          end
        end
        ACT_START: begin
          if (!playing) begin
            playing  = 1'b1;
            elapsed  = '0;
            looping  = beat.loop_enable;
            period   = beat.frame_period;
            position = '0;
          end
        end
        ACT_STOP: clear_table();
        ACT_SET:  shown = beat.frame_number;
        default: ;
      endcase
      if (prior != {playing, looping, elapsed, period, position, count, shown})
        effective_items++;
      pending_coords.push_back(coords());
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    // Checks one accepted result beat against the oldest prediction.
    function void check_coords(sas_out_t got);
      sas_out_t want;
      if (pending_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result beat with no prediction waiting: %h", got);
        return;
      end
      want = pending_coords.pop_front();
      compare_field("u_left", want.u_left, got.u_left);
      compare_field("v_top", want.v_top, got.v_top);
      compare_field("u_right", want.u_right, got.u_right);
      compare_field("v_bottom", want.v_bottom, got.v_bottom);
      compare_field("shown_frame_out", want.shown_frame_out, got.shown_frame_out);
      compare_field("is_playing", want.is_playing, got.is_playing);
      compare_field("entries_loaded", want.entries_loaded, got.entries_loaded);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  sas_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  sas_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_TEX_W;
  logic [CFG_W-1:0] cfg_data = '0;

  frame_coord_scoreboard sb = new();

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 47;
  logic        stall_rx = 1'b0;

  sprite_animation_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Input monitor: every accepted beat updates the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_item(in_data);
  end

  // Result side: check accepted beats and drive a randomly stalling ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_coords(out_data);
      out_ready <= !stall_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off in mid run so that the block backs up its input.
  initial begin
    while (sb.effective_items < 220) @(posedge clk);
    stall_rx <= 1'b1;
    repeat (500) @(posedge clk);
    stall_rx <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Offers one beat after a random gap and holds it until accepted.
  task automatic send_action(input logic [2:0] act, input logic [19:0] delta,
                             input logic [11:0] frame, input logic [19:0] per,
                             input logic loop_en);
    sas_in_t beat;
    beat.action       = act;
    beat.time_delta   = delta;
    beat.frame_number = frame;
    beat.frame_period = per;
    beat.loop_enable  = loop_en;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Offers one beat of the given action with every other field random.
  task automatic send_noise(input logic [2:0] act);
    send_action(act, 20'($urandom), 12'($urandom), 20'($urandom), 1'($urandom));
  endtask

  // Stops offering and waits until every predicted beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_geometry(input int unsigned sw, input int unsigned sh,
                                input int unsigned tw, input int unsigned th);
    write_reg(REG_TEX_W, CFG_W'(sw));
    write_reg(REG_TEX_H, CFG_W'(sh));
    write_reg(REG_TILE_W, CFG_W'(tw));
    write_reg(REG_TILE_H, CFG_W'(th));
    cfg_we <= 1'b0;
  endtask

  // One playback scene: mostly stop, load, start and ticks; sometimes noise.
  task automatic play_scene();
    int unsigned n_frames, n_ticks, span, pick;
    logic [19:0] per;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6))
        send_noise(3'($urandom_range(7)));
      return;
    end
    send_noise(ACT_STOP);
    n_frames = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    repeat (n_frames) send_noise(ACT_LOAD);
    if ($urandom_range(3) == 0) send_noise(ACT_SET);
    case ($urandom_range(3))
      0: per = 20'($urandom_range(0, 20'hFFFFF));
      1: per = 20'($urandom_range(0, 16));
      default: per = 20'($urandom_range(1, 20'h1FFF));
    endcase
    send_action(ACT_START, 20'($urandom), 12'($urandom), per, 1'($urandom));
    span = per * 2 + 1;
    if (span > 20'hFFFFF) span = 20'hFFFFF;
    n_ticks = $urandom_range(2, (3 * n_frames + 4 > 40) ? 40 : 3 * n_frames + 4);
    repeat (n_ticks) begin
      pick = $urandom_range(99);
      if (pick < 5)
        send_noise(ACT_SET);
      else if (pick < 8)
        send_noise(ACT_LOAD);
      else if (pick < 10)
        send_noise(ACT_START);
      else if (pick < 18)
        send_noise(ACT_TICK);
      else
        send_action(ACT_TICK, 20'($urandom_range(0, span)), 12'($urandom), 20'($urandom),
                    1'($urandom));
    end
  endtask

  int unsigned geometry [6][4] = '{
    '{4096, 4096, 1, 1},
    '{1, 1, 4096, 4096},
    '{0, 0, 0, 0},
    '{8191, 8191, 8191, 8191},
    '{300, 20, 100, 7},
    '{256, 256, 16, 16}
  };

  // Main stimulus: directed beats at reset geometry, then random segments.
  initial begin
    int unsigned target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ticks while stopped, frame extremes, loads and ignored commands.
    send_action(ACT_TICK, 20'hFFFFF, 12'h000, 20'h00001, 1'b0);
    send_action(ACT_SET, 20'h00000, 12'hFFF, 20'hFFFFF, 1'b1);
    send_action(ACT_SET, 20'hFFFFF, 12'h000, 20'h00000, 1'b0);
    send_action(ACT_LOAD, 20'h00000, 12'hFFF, 20'h00000, 1'b0);
    send_action(ACT_LOAD, 20'hFFFFF, 12'h000, 20'hFFFFF, 1'b1);
    send_action(ACT_LOAD, 20'h5A5A5, 12'h5A5, 20'hA5A5A, 1'b0);
    send_action(ACT_TICK, 20'h00010, 12'h000, 20'h00000, 1'b0);
    // Zero period: every nonzero tick advances, looping wraps around.
    send_action(ACT_START, 20'h00000, 12'h000, 20'h00000, 1'b1);
    send_action(ACT_LOAD, 20'h00000, 12'h123, 20'h00000, 1'b0);
    send_action(ACT_START, 20'h00000, 12'h000, 20'hFFFFF, 1'b0);
    send_action(ACT_TICK, 20'h00000, 12'h000, 20'h00000, 1'b0);
    send_action(ACT_TICK, 20'h00001, 12'h000, 20'h00000, 1'b0);
    send_action(ACT_TICK, 20'hFFFFF, 12'h000, 20'h00000, 1'b0);
    send_action(ACT_TICK, 20'hFFFFF, 12'h000, 20'h00000, 1'b0);
    // Elapsed time saturates here.
    send_action(ACT_TICK, 20'hFFFFF, 12'h000, 20'h00000, 1'b0);
    send_action(ACT_STOP, 20'h00000, 12'h000, 20'h00000, 1'b0);
    send_action(3'd5, 20'hFFFFF, 12'hFFF, 20'hFFFFF, 1'b1);
    send_action(3'd6, 20'h00000, 12'h000, 20'h00000, 1'b0);
    send_action(3'd7, 20'hFFFFF, 12'hFFF, 20'hFFFFF, 1'b1);
    // Start on an empty table plays nothing until stop.
    send_action(ACT_START, 20'h00000, 12'h000, 20'hFFFFF, 1'b0);
    send_action(ACT_TICK, 20'hFFFFF, 12'h000, 20'h00000, 1'b0);
    send_action(ACT_STOP, 20'h00000, 12'h000, 20'h00000, 1'b0);
    // Non-looping run past the end stops and keeps the shown frame.
    send_action(ACT_LOAD, 20'h00000, 12'h007, 20'h00000, 1'b0);
    send_action(ACT_LOAD, 20'h00000, 12'h009, 20'h00000, 1'b0);
    send_action(ACT_START, 20'h00000, 12'h000, 20'h00001, 1'b0);
    send_action(ACT_TICK, 20'h00002, 12'h000, 20'h00000, 1'b0);
    send_action(ACT_TICK, 20'h00002, 12'h000, 20'h00000, 1'b0);

    geometry[5] = '{$urandom_range(1, 4096), $urandom_range(1, 4096),
                    $urandom_range(1, 64), $urandom_range(1, 64)};
    target = sb.effective_items;
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      apply_geometry(geometry[seg][0], geometry[seg][1], geometry[seg][2], geometry[seg][3]);
      if (seg < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 47;
      end else if (seg < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      target = target + 120;
      while (sb.effective_items < target) play_scene();
    end

    drain();
    repeat (150) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
